/* hw/rtl/rse_pkg.sv */
// Shared types and constants for the rank sort engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

	localparam int unsigned SET_CAPACITY = 16;

	typedef struct packed {
		logic signed [31:0] item_value;
		logic               set_end;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               run_end;
		logic               overflow;
	} out_item_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic               occupied;
		logic               keep;
		logic signed [31:0] value;
	} cell_link_t;

endpackage

`default_nettype wire

/* hw/rtl/rse_cell.sv */
// One cell of the sorted chain: holds one value, and inserts an arrival or shifts when told.
// Depends on rse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rse_cell
	import rse_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               insert,
	input  wire logic               shift,
	input  wire logic signed [31:0] arrival,
	input  wire cell_link_t         prev,
	input  wire cell_link_t         next,
	output cell_link_t              own
);

	logic               occ_q;
	logic signed [31:0] value_q;
	logic               keep;

	// stored value stays ahead of an arrival that is greater or equal
	assign keep = occ_q && (value_q <= arrival);

	assign own = '{occupied: occ_q, keep: keep, value: value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (shift) begin
			occ_q <= next.occupied;
		end else if (insert && !keep) begin
			occ_q <= prev.keep ? 1'b1 : prev.occupied;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= next.value;
		end else if (insert && !keep) begin
			value_q <= prev.keep ? arrival : prev.value;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rank_sort_engine_core.sv */
// Top level of the rank sort engine: chain of sort cells, fill count, drain control.
// Depends on rse_pkg and rse_cell.
`timescale 1ns / 1ps
`default_nettype none

// Sorts sets of up to SET_CAPACITY signed 32-bit values, stable for equal values.
// Values are taken one item per cycle while loading; each arrival is broadcast to a
// row of cells kept in ascending order, and the cells open a slot for it as it is taken.
// The item marked set_end starts the drain: the head cell is emitted once per cycle
// (while result_ready holds) as the row shifts toward the head, so a set of N values
// yields N results, with run_end on the last one. item_ready is low during the
// drain. Arrivals beyond capacity are dropped and every result of that set carries
// overflow.
module rank_sort_engine_core
	import rse_pkg::*;
#(
	parameter int unsigned SET_CAPACITY_P = SET_CAPACITY
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire in_item_t  item,
	output logic           result_valid,
	input  wire logic      result_ready,
	output out_item_t      result
);

	localparam int unsigned CW = $clog2(SET_CAPACITY_P + 1);

	logic          drain_q;
	logic          ovf_q;
	logic [CW-1:0] fill_q;
	logic          res_valid_q;
	out_item_t     res_q;

	logic in_fire, full, ins, pop;

	cell_link_t own_lnk  [SET_CAPACITY_P];
	cell_link_t prev_lnk [SET_CAPACITY_P];
	cell_link_t next_lnk [SET_CAPACITY_P];

	assign item_ready   = !drain_q;
	assign in_fire      = item_valid && item_ready;
	assign full         = (fill_q == CW'(SET_CAPACITY_P));
	assign ins          = in_fire && !full;
	assign pop          = drain_q && (!res_valid_q || result_ready);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		for (int i = 0; i < SET_CAPACITY_P; i++) begin
			if (i == 0) begin
				prev_lnk[i] = '{occupied: 1'b1, keep: 1'b1, value: '0};
			end else begin
				prev_lnk[i] = own_lnk[i-1];
			end
			if (i == SET_CAPACITY_P - 1) begin
				next_lnk[i] = '{occupied: 1'b0, keep: 1'b0, value: '0};
			end else begin
				next_lnk[i] = own_lnk[i+1];
			end
		end
	end

	for (genvar g = 0; g < SET_CAPACITY_P; g++) begin : g_cell
		rse_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.insert  (ins),
			.shift   (pop),
			.arrival (item.item_value),
			.prev    (prev_lnk[g]),
			.next    (next_lnk[g]),
			.own     (own_lnk[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= 1'b0;
			ovf_q       <= 1'b0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
				if (item.set_end) begin
					drain_q <= 1'b1;
				end
			end
			if (pop) begin
				res_valid_q <= 1'b1;
				fill_q      <= fill_q - CW'(1);
				if (fill_q == CW'(1)) begin
					drain_q <= 1'b0;
					ovf_q   <= 1'b0;
				end
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.sorted_value <= own_lnk[0].value;
			res_q.run_end      <= (fill_q == CW'(1));
			res_q.overflow     <= ovf_q;
		end
	end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for rank_sort_engine_core: directed sets, then random sets.
// Depends on rse_pkg and the engine RTL. A predictor sorts each set and checks every result.
`timescale 1ns / 1ps

module testbench;
	import rse_pkg::*;

	localparam int LIMIT        = 200000;
	localparam int RANDOM_ITEMS = 350;

	typedef struct {
		in_item_t  item;
		bit        fixed;
		out_item_t want;
	} step_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	logic signed [31:0] open_set[$];
	bit                 open_overflow;
	out_item_t          sorted_due[$];
	bit                 no_gaps;
	int                 cycles, failures, sent, sets_closed, overflow_sets, results_seen;

	rank_sort_engine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("rank_sort_engine_core test failed");
			$finish;
		end
	end

	// stable insert: a new value goes after every stored value <= it
	function automatic void absorb_item(in_item_t x);
		int        pos;
		int        n;
		out_item_t y;
		if (open_set.size() < SET_CAPACITY) begin
			pos = 0;
			while (pos < open_set.size() && open_set[pos] <= $signed(x.item_value))
				pos++;
			open_set.insert(pos, $signed(x.item_value));
		end else begin
			open_overflow = 1'b1;
		end
		if (x.set_end) begin
			n = open_set.size();
			for (int k = 0; k < n; k++) begin
				y.sorted_value = open_set[k];
				y.run_end      = (k == n - 1);
				y.overflow     = open_overflow;
				sorted_due.push_back(y);
			end
			sets_closed++;
			if (open_overflow)
				overflow_sets++;
			open_set.delete();
			open_overflow = 1'b0;
		end
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (sorted_due.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result: value %0d end %0b ovf %0b",
					got.sorted_value, got.run_end, got.overflow);
			return;
		end
		want = sorted_due.pop_front();
		if (got !== want) begin
			failures++;
			if (failures <= 10)
				$display("mismatch: expected value %0d end %0b ovf %0b, got value %0d end %0b ovf %0b",
					want.sorted_value, want.run_end, want.overflow,
					got.sorted_value, got.run_end, got.overflow);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				check_result(result);
			result_ready <= no_gaps || ($urandom_range(99) >= 15);
		end
	end

	task automatic send_item(in_item_t x);
		while (!no_gaps && $urandom_range(99) < 15) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= x;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		absorb_item(x);
		sent++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: pick_value = $urandom_range(14) - 7;
			4: begin
				case ($urandom_range(3))
					0:       pick_value = 32'h7FFFFFFF;
					1:       pick_value = 32'h80000000;
					2:       pick_value = 32'h0;
					default: pick_value = 32'hFFFFFFFF;
				endcase
			end
			5: pick_value = ($urandom_range(1) ? 32'h7FFFFFF0 : 32'h80000000) + $urandom_range(15);
			default: pick_value = $urandom;
		endcase
	endfunction

	// single-value set: the result is the value itself
	function automatic step_row_t fx(logic [31:0] v);
		fx.item  = '{v, 1'b1};
		fx.fixed = 1'b1;
		fx.want  = '{v, 1'b1, 1'b0};
	endfunction

	function automatic step_row_t mk(logic [31:0] v, bit e);
		mk.item  = '{v, e};
		mk.fixed = 1'b0;
		mk.want  = '0;
	endfunction

	initial begin
		step_row_t plan[];
		in_item_t  x;
		int        set_len;
		plan = '{
			fx(32'h7FFFFFFF), fx(32'h80000000), fx(32'h0), fx(32'hFFFFFFFF),
			mk(5, 0), mk(-3, 0), mk(32'h80000000, 0), mk(5, 1),
			// 16 fill the store, the set_end item is dropped
			mk(9, 0), mk(-9, 0), mk(7, 0), mk(7, 0), mk(32'h7FFFFFFF, 0), mk(-1, 0),
			mk(0, 0), mk(3, 0), mk(-20, 0), mk(3, 0), mk(100, 0), mk(-100, 0),
			mk(1, 0), mk(2, 0), mk(32'h80000000, 0), mk(-1, 0), mk(42, 1)
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_item(plan[i].item);
			if (plan[i].fixed) begin
				void'(sorted_due.pop_back());
				sorted_due.push_back(plan[i].want);
			end
		end

		while (sent < plan.size() + RANDOM_ITEMS) begin
			set_len = ($urandom_range(7) == 0) ? $urandom_range(17, 24)
				: $urandom_range(1, SET_CAPACITY);
			for (int k = 0; k < set_len; k++) begin
				no_gaps        = (sent >= 150 && sent < 230);
				x.item_value   = pick_value();
				x.set_end      = (k == set_len - 1);
				send_item(x);
			end
		end
		item_valid <= 1'b0;
		no_gaps = 1'b0;

		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items in %0d sets, %0d of them over capacity", sent, sets_closed,
			overflow_sets);
		$display("%0d results checked, %0d failures", results_seen, failures);
		if (failures == 0 && sorted_due.size() == 0) begin
			$display("rank_sort_engine_core test passed");
		end else begin
			$display("rank_sort_engine_core test failed");
		end
		$finish;
	end

endmodule

/* rank_sort_engine_core.f */
hw/rtl/rse_pkg.sv
hw/rtl/rse_cell.sv
hw/rtl/rank_sort_engine_core.sv
sim/testbench.sv
